// File: hw/rtl/cdbs_pkg.sv
// Shared types, constants and helper functions for the character display
// bus sequencer. No dependencies; every file but the two interfaces uses it by scoped names.
`default_nettype none

package cdbs_pkg;

    localparam int PAUSE_W   = 16;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    localparam logic [7:0] REG_DIR_A  = 8'h00;
    localparam logic [7:0] REG_DIR_B  = 8'h01;
    localparam logic [7:0] REG_PORT_A = 8'h12;
    localparam logic [7:0] REG_PORT_B = 8'h13;

    localparam logic [7:0] BYTE_CLEAR     = 8'h01;
    localparam logic [7:0] BYTE_SET_DDRAM = 8'h80;
    localparam logic [7:0] CURSOR_MAX     = 8'h27;
    localparam logic [7:0] CURSOR_SKIP    = 8'h40 - 8'h28;

    localparam logic [PAUSE_W-1:0] INIT_PAUSE_RST  = 16'd10000;
    localparam logic [PAUSE_W-1:0] CLEAR_PAUSE_RST = 16'd2000;

    // prelude writes of init: dir A, dir B, port A, port B, port B
    localparam logic [2:0] PRE_LAST  = 3'd4;
    // eight setup bytes follow the prelude
    localparam logic [2:0] INIT_LAST = 3'd7;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_CURSOR = 2'd2,
        OP_WRITE  = 2'd3
    } t_opcode;

    typedef enum logic {
        CFG_INIT_PAUSE  = 1'b0,
        CFG_CLEAR_PAUSE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        WT_NONE,
        WT_INIT,
        WT_CLEAR
    } t_wait_sel;

    typedef enum logic {
        KIND_BYTE,
        KIND_INIT
    } t_kind;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PRE,
        BK_MODE,
        BK_EN,
        BK_DATA,
        BK_CLR
    } t_bk_state;

    typedef struct packed {
        t_kind      kind;
        logic       need_mode;
        logic       mode;
        logic [7:0] data;
        t_wait_sel  wsel;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_qpush;

    typedef struct packed {
        logic   empty;
        t_entry entry;
    } t_qhead;

    typedef struct packed {
        logic [PAUSE_W-1:0] init_pause;
        logic [PAUSE_W-1:0] clear_pause;
    } t_pause;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0, 3'd1, 3'd2: b = 8'h30;
            3'd3:             b = 8'h38;
            3'd4:             b = 8'h10;
            3'd5:             b = BYTE_CLEAR;
            3'd6:             b = 8'h06;
            default:          b = 8'h0C;
        endcase
        return b;
    endfunction

    function automatic t_wait_sel init_wait(input logic [2:0] idx);
        t_wait_sel w;
        case (idx)
            3'd0, 3'd1, 3'd2: w = WT_INIT;
            3'd5:             w = WT_CLEAR;
            default:          w = WT_NONE;
        endcase
        return w;
    endfunction

    function automatic t_bk_state first_state(input t_entry e);
        t_bk_state s;
        if (e.kind == KIND_INIT) begin
            s = BK_PRE;
        end else if (e.need_mode) begin
            s = BK_MODE;
        end else begin
            s = BK_EN;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cdbs_cmd_if.sv
// Command channel: valid/ready handshake carrying opcode and payload.
// Depends on nothing.
`default_nettype none

interface cdbs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] payload;

    modport source (output valid, output opcode, output payload, input ready);
    modport sink   (input valid, input opcode, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cdbs_wr_if.sv
// Expander write channel: valid/ready handshake carrying one register write.
// Depends on nothing.
`default_nettype none

interface cdbs_wr_if;
    logic        valid;
    logic        ready;
    logic [7:0]  dest_reg;
    logic [7:0]  reg_value;
    logic [15:0] wait_us;
    logic        last;

    modport source (output valid, output dest_reg, output reg_value,
                    output wait_us, output last, input ready);
    modport sink   (input valid, input dest_reg, input reg_value,
                    input wait_us, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cdbs_front.sv
// Front end: accepts commands, tracks register-select mode, builds queue entries.
// Depends on cdbs_pkg and cdbs_cmd_if.
`default_nettype none

module cdbs_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    cdbs_cmd_if.sink           i_cmd,
    input  wire                i_q_full,
    output cdbs_pkg::t_qpush   o_qpush
);

    logic             r_rs_mode;
    logic             n_rs_mode;
    logic             accept;
    logic [7:0]       pos;
    cdbs_pkg::t_entry entry;

    assign i_cmd.ready = !i_q_full;
    assign accept      = i_cmd.valid && !i_q_full;

    always_comb begin
        pos             = i_cmd.payload;
        entry.kind      = cdbs_pkg::KIND_BYTE;
        entry.need_mode = 1'b0;
        entry.mode      = 1'b0;
        entry.data      = i_cmd.payload;
        entry.wsel      = cdbs_pkg::WT_NONE;
        n_rs_mode       = 1'b0;
        // jump past the hidden tail of line one into line two
        if (i_cmd.payload > cdbs_pkg::CURSOR_MAX) begin
            pos = i_cmd.payload + cdbs_pkg::CURSOR_SKIP;
        end
        case (cdbs_pkg::t_opcode'(i_cmd.opcode))
            cdbs_pkg::OP_INIT: begin
                entry.kind = cdbs_pkg::KIND_INIT;
            end
            cdbs_pkg::OP_CLEAR: begin
                entry.need_mode = r_rs_mode;
                entry.data      = cdbs_pkg::BYTE_CLEAR;
                entry.wsel      = cdbs_pkg::WT_CLEAR;
            end
            cdbs_pkg::OP_CURSOR: begin
                entry.need_mode = r_rs_mode;
                entry.data      = cdbs_pkg::BYTE_SET_DDRAM | pos;
            end
            default: begin
                entry.need_mode = !r_rs_mode;
                entry.mode      = 1'b1;
                n_rs_mode       = 1'b1;
            end
        endcase
    end

    assign o_qpush.push  = accept;
    assign o_qpush.entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_mode <= 1'b0;
        end else if (accept) begin
            r_rs_mode <= n_rs_mode;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cdbs_queue.sv
// Small FIFO of decoded commands between front end and write sequencer.
// Depends on cdbs_pkg.
`default_nettype none

module cdbs_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  cdbs_pkg::t_qpush  i_qpush,
    input  wire               i_pop,
    output logic              o_full,
    output cdbs_pkg::t_qhead  o_head
);

    cdbs_pkg::t_entry                 r_mem [cdbs_pkg::Q_DEPTH];
    logic [cdbs_pkg::Q_PTR_W-1:0]     r_wp;
    logic [cdbs_pkg::Q_PTR_W-1:0]     r_rp;
    logic [cdbs_pkg::Q_PTR_W:0]       r_cnt;
    logic                             do_push;
    logic                             do_pop;

    assign o_full       = (r_cnt == (cdbs_pkg::Q_PTR_W+1)'(cdbs_pkg::Q_DEPTH));
    assign o_head.empty = (r_cnt == '0);
    assign o_head.entry = r_mem[r_rp];
    assign do_push      = i_qpush.push && !o_full;
    assign do_pop       = i_pop && !o_head.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_qpush.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cdbs_back.sv
// Write sequencer: expands queued commands into expander register writes
// behind an output register. Depends on cdbs_pkg and cdbs_wr_if.
`default_nettype none

module cdbs_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  cdbs_pkg::t_qhead   i_head,
    input  cdbs_pkg::t_pause   i_pause,
    output logic               o_pop,
    cdbs_wr_if.source          o_wr
);

    cdbs_pkg::t_bk_state  r_state, n_state;
    cdbs_pkg::t_entry     r_cur, n_cur;
    logic [2:0]           r_pre, n_pre;
    logic [2:0]           r_idx, n_idx;

    logic                 r_ov;
    logic [7:0]           r_addr;
    logic [7:0]           r_val;
    logic [15:0]          r_wait;
    logic                 r_last;

    logic                 adv;
    logic [7:0]           w_addr;
    logic [7:0]           w_val;
    cdbs_pkg::t_wait_sel  w_sel;
    logic                 w_last;
    logic [15:0]          w_wait;

    assign adv = (r_state != cdbs_pkg::BK_IDLE) && (!r_ov || o_wr.ready);

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_pre   = r_pre;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        w_addr  = cdbs_pkg::REG_PORT_B;
        w_val   = 8'h00;
        w_sel   = cdbs_pkg::WT_NONE;
        w_last  = 1'b0;
        case (r_state)
            cdbs_pkg::BK_IDLE: begin
                if (!i_head.empty) begin
                    o_pop   = 1'b1;
                    n_cur   = i_head.entry;
                    n_state = cdbs_pkg::first_state(i_head.entry);
                    n_pre   = '0;
                    n_idx   = '0;
                end
            end
            cdbs_pkg::BK_PRE: begin
                case (r_pre)
                    3'd0:    w_addr = cdbs_pkg::REG_DIR_A;
                    3'd1:    w_addr = cdbs_pkg::REG_DIR_B;
                    3'd2:    w_addr = cdbs_pkg::REG_PORT_A;
                    default: w_addr = cdbs_pkg::REG_PORT_B;
                endcase
                if (adv) begin
                    if (r_pre == cdbs_pkg::PRE_LAST) begin
                        n_state = cdbs_pkg::BK_EN;
                    end else begin
                        n_pre = r_pre + 3'd1;
                    end
                end
            end
            cdbs_pkg::BK_MODE: begin
                w_val = {7'b0, r_cur.mode};
                if (adv) begin
                    n_state = cdbs_pkg::BK_EN;
                end
            end
            cdbs_pkg::BK_EN: begin
                w_val = {6'b0, 1'b1, r_cur.mode};
                if (adv) begin
                    n_state = cdbs_pkg::BK_DATA;
                end
            end
            cdbs_pkg::BK_DATA: begin
                w_addr = cdbs_pkg::REG_PORT_A;
                w_val  = (r_cur.kind == cdbs_pkg::KIND_INIT) ?
                         cdbs_pkg::init_byte(r_idx) : r_cur.data;
                if (adv) begin
                    n_state = cdbs_pkg::BK_CLR;
                end
            end
            cdbs_pkg::BK_CLR: begin
                w_val = {7'b0, r_cur.mode};
                if (r_cur.kind == cdbs_pkg::KIND_INIT) begin
                    w_sel  = cdbs_pkg::init_wait(r_idx);
                    w_last = (r_idx == cdbs_pkg::INIT_LAST);
                end else begin
                    w_sel  = r_cur.wsel;
                    w_last = 1'b1;
                end
                if (adv) begin
                    if (!w_last) begin
                        n_idx   = r_idx + 3'd1;
                        n_state = cdbs_pkg::BK_EN;
                    end else if (!i_head.empty) begin
                        // chain straight into the next command
                        o_pop   = 1'b1;
                        n_cur   = i_head.entry;
                        n_state = cdbs_pkg::first_state(i_head.entry);
                        n_pre   = '0;
                        n_idx   = '0;
                    end else begin
                        n_state = cdbs_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = cdbs_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        case (w_sel)
            cdbs_pkg::WT_INIT:  w_wait = i_pause.init_pause;
            cdbs_pkg::WT_CLEAR: w_wait = i_pause.clear_pause;
            default:            w_wait = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdbs_pkg::BK_IDLE;
            r_pre   <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pre   <= n_pre;
            r_idx   <= n_idx;
            if (adv) begin
                r_ov <= 1'b1;
            end else if (o_wr.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (adv) begin
            r_addr <= w_addr;
            r_val  <= w_val;
            r_wait <= w_wait;
            r_last <= w_last;
        end
    end

    assign o_wr.valid     = r_ov;
    assign o_wr.dest_reg  = r_addr;
    assign o_wr.reg_value = r_val;
    assign o_wr.wait_us   = r_wait;
    assign o_wr.last      = r_last;

endmodule

`default_nettype wire

// File: hw/rtl/char_display_bus_sequencer_top.sv
// Top level of the character display bus sequencer: config registers and wiring.
// Depends on cdbs_pkg, cdbs_cmd_if, cdbs_wr_if, cdbs_front, cdbs_queue, cdbs_back.
`default_nettype none

// Each command on i_cmd becomes a burst of expander register writes on o_wr,
// the final one flagged by last and each carrying the pause to observe after it.
// A command lands in a four-entry command queue; the front end keeps
// accepting while the queue has room. The write sequencer drains the queue at
// one write per cycle while o_wr is taken: clear, set cursor and write
// character produce three writes, or four when the register-select mode
// changes, and init produces 29. Throughput of ordinary commands is set by
// the single write port of the sequencer. Pause values are written through
// i_cfg_* (index 0 init pause, 1 clear pause); the user must write them only
// while the block is idle, and the block itself does not enforce this.

module char_display_bus_sequencer_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    cdbs_cmd_if.sink     i_cmd,
    cdbs_wr_if.source    o_wr,
    input  wire          i_cfg_we,
    input  wire          i_cfg_idx,
    input  wire [15:0]   i_cfg_data
);

    cdbs_pkg::t_pause  r_pause;
    cdbs_pkg::t_qpush  qpush;
    cdbs_pkg::t_qhead  qhead;
    logic              q_full;
    logic              q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause.init_pause  <= cdbs_pkg::INIT_PAUSE_RST;
            r_pause.clear_pause <= cdbs_pkg::CLEAR_PAUSE_RST;
        end else if (i_cfg_we) begin
            case (cdbs_pkg::t_cfg_idx'(i_cfg_idx))
                cdbs_pkg::CFG_INIT_PAUSE:  r_pause.init_pause  <= i_cfg_data;
                cdbs_pkg::CFG_CLEAR_PAUSE: r_pause.clear_pause <= i_cfg_data;
                default:                   r_pause <= r_pause;
            endcase
        end
    end

    cdbs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_q_full(q_full),
        .o_qpush (qpush)
    );

    cdbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qpush (qpush),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (qhead)
    );

    cdbs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (qhead),
        .i_pause (r_pause),
        .o_pop   (q_pop),
        .o_wr    (o_wr)
    );

endmodule

`default_nettype wire

// File: hw/rtl/cdbs_checker.sv
// Port-level checker for the sequencer output channel, bound to the top level.
// Depends on char_display_bus_sequencer_top and cdbs_pkg.
`default_nettype none

module cdbs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_wr_valid,
    input wire        i_wr_ready,
    input wire [7:0]  i_wr_addr,
    input wire [7:0]  i_wr_value,
    input wire [15:0] i_wr_wait,
    input wire        i_wr_last
);

    // a pending write holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid && !i_wr_ready |=> i_wr_valid && $stable(i_wr_addr)
            && $stable(i_wr_value) && $stable(i_wr_wait) && $stable(i_wr_last))
        else $error("write request dropped or changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_wr_valid)
        else $error("write request right after reset");

    // every command ends with an enable-clear write to port B
    a_last_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid && i_wr_last |-> i_wr_addr == cdbs_pkg::REG_PORT_B
            && i_wr_value[1] == 1'b0)
        else $error("last write is not an enable-clear on port B");

    a_wait_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid && i_wr_wait != 16'd0 |-> i_wr_addr == cdbs_pkg::REG_PORT_B
            && i_wr_value[1] == 1'b0)
        else $error("pause attached to a write other than enable-clear");

    // a nonzero data byte on port A is never flagged as the last write
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid && i_wr_ready && i_wr_addr == cdbs_pkg::REG_PORT_A
            && i_wr_value != 8'h00 |-> i_wr_last == 1'b0)
        else $error("data byte flagged as last write");

endmodule

bind char_display_bus_sequencer_top cdbs_checker u_cdbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_wr_valid (o_wr.valid),
    .i_wr_ready (o_wr.ready),
    .i_wr_addr  (o_wr.dest_reg),
    .i_wr_value (o_wr.reg_value),
    .i_wr_wait  (o_wr.wait_us),
    .i_wr_last  (o_wr.last)
);

`default_nettype wire

// File: test/tb_char_display_bus_sequencer_top.sv
// Self-checking testbench for char_display_bus_sequencer_top: display commands in, expander
// register writes out, every write checked against an in-bench expansion of the command or a hand-written burst.
// Depends on cdbs_pkg, cdbs_cmd_if, cdbs_wr_if and the RTL under hw/rtl.
`default_nettype none

module tb_char_display_bus_sequencer_top;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RX_HOLD_CYCLES = 100;
    localparam int TAIL_CYCLES    = 8;
    localparam int PHASE_ITEMS    = 42;
    localparam int NUM_PHASES     = 5;

    // display bus bytes and bit fields of the control port
    localparam logic [7:0] LCD_WAKE      = 8'h30;
    localparam logic [7:0] LCD_FUNC_SET  = 8'h38;
    localparam logic [7:0] LCD_SHIFT     = 8'h10;
    localparam logic [7:0] LCD_CLEAR     = 8'h01;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [7:0] LCD_DDRAM     = 8'h80;
    localparam logic [7:0] LINE1_LAST    = 8'h27;
    localparam logic [7:0] LINE2_OFFSET  = 8'h18;
    localparam logic [7:0] CTRL_ENABLE   = 8'h02;
    localparam logic [7:0] CTRL_CMD_MODE = 8'h00;

    typedef struct packed {
        logic [7:0]  addr;
        logic [7:0]  value;
        logic [15:0] pause;
        logic        last;
    } exp_wr_t;

    typedef struct {
        cdbs_pkg::t_opcode op;
        logic [7:0]        pay;
        bit                typed;
        bit                mode_wr;
        logic [7:0]        bus_byte;
        logic [15:0]       pause;
    } cmd_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    cdbs_pkg::t_cfg_idx cfg_idx;
    logic [15:0]        cfg_data;

    cdbs_cmd_if cmd_bus ();
    cdbs_wr_if  wr_bus ();

    char_display_bus_sequencer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd      (cmd_bus),
        .o_wr       (wr_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mirror of the block's state and pause registers
    logic        rs_mode_q;
    logic [15:0] init_pause_q;
    logic [15:0] clear_pause_q;

    exp_wr_t burst [0:28];
    int      burst_len;
    exp_wr_t pending_writes [$];

    int  errors      = 0;
    int  n_cmds      = 0;
    int  n_writes    = 0;
    int  n_inits     = 0;
    int  quiet_cycles = 0;
    bit  idle_on     = 1'b1;
    bit  rx_hold_req = 1'b0;

    // expected port A byte is typed in where it reads straight off the command
    cmd_row_t directed_rows [0:20] = '{
        '{cdbs_pkg::OP_CLEAR,  8'h5A, 1'b1, 1'b0, 8'h01, 16'd2000},
        '{cdbs_pkg::OP_WRITE,  8'h00, 1'b1, 1'b1, 8'h00, 16'd0},
        '{cdbs_pkg::OP_WRITE,  8'hFF, 1'b1, 1'b0, 8'hFF, 16'd0},
        '{cdbs_pkg::OP_CURSOR, 8'h00, 1'b1, 1'b1, 8'h80, 16'd0},
        '{cdbs_pkg::OP_CURSOR, 8'h27, 1'b1, 1'b0, 8'hA7, 16'd0},
        '{cdbs_pkg::OP_CURSOR, 8'h28, 1'b1, 1'b0, 8'hC0, 16'd0},
        '{cdbs_pkg::OP_CURSOR, 8'hFF, 1'b1, 1'b0, 8'h97, 16'd0},
        '{cdbs_pkg::OP_CURSOR, 8'hE8, 1'b1, 1'b0, 8'h80, 16'd0},
        '{cdbs_pkg::OP_CURSOR, 8'h55, 1'b1, 1'b0, 8'hED, 16'd0},
        '{cdbs_pkg::OP_WRITE,  8'hA5, 1'b1, 1'b1, 8'hA5, 16'd0},
        '{cdbs_pkg::OP_INIT,   8'hFF, 1'b0, 1'b0, 8'h00, 16'd0},
        '{cdbs_pkg::OP_WRITE,  8'h5A, 1'b0, 1'b0, 8'h00, 16'd0},
        '{cdbs_pkg::OP_CLEAR,  8'h00, 1'b0, 1'b0, 8'h00, 16'd0},
        '{cdbs_pkg::OP_WRITE,  8'h80, 1'b0, 1'b0, 8'h00, 16'd0},
        '{cdbs_pkg::OP_INIT,   8'h00, 1'b0, 1'b0, 8'h00, 16'd0},
        '{cdbs_pkg::OP_INIT,   8'h3C, 1'b0, 1'b0, 8'h00, 16'd0},
        '{cdbs_pkg::OP_CLEAR,  8'hFF, 1'b1, 1'b0, 8'h01, 16'd2000},
        '{cdbs_pkg::OP_CURSOR, 8'h7F, 1'b0, 1'b0, 8'h00, 16'd0},
        '{cdbs_pkg::OP_WRITE,  8'h7F, 1'b0, 1'b0, 8'h00, 16'd0},
        '{cdbs_pkg::OP_CLEAR,  8'hAA, 1'b1, 1'b1, 8'h01, 16'd2000},
        '{cdbs_pkg::OP_CURSOR, 8'h01, 1'b0, 1'b0, 8'h00, 16'd0}
    };

    function automatic void emit_wr(input logic [7:0] a, input logic [7:0] v,
                                    input logic [15:0] p);
        burst[burst_len] = '{addr: a, value: v, pause: p, last: 1'b0};
        burst_len++;
    endfunction

    function automatic void send_bus_byte(input logic [7:0] b, input logic m,
                                          input logic [15:0] p);
        emit_wr(cdbs_pkg::REG_PORT_B, CTRL_ENABLE | {7'b0, m}, 16'd0);
        emit_wr(cdbs_pkg::REG_PORT_A, b, 16'd0);
        emit_wr(cdbs_pkg::REG_PORT_B, {7'b0, m}, p);
    endfunction

    function automatic void switch_mode(input logic m);
        if (rs_mode_q != m) begin
            emit_wr(cdbs_pkg::REG_PORT_B, {7'b0, m}, 16'd0);
        end
        rs_mode_q = m;
    endfunction

    // expand one display command into its expander writes
    function automatic void expand_cmd(input cdbs_pkg::t_opcode op, input logic [7:0] pay);
        logic [7:0] pos;
        burst_len = 0;
        case (op)
            cdbs_pkg::OP_INIT: begin
                emit_wr(cdbs_pkg::REG_DIR_A, 8'h00, 16'd0);
                emit_wr(cdbs_pkg::REG_DIR_B, 8'h00, 16'd0);
                emit_wr(cdbs_pkg::REG_PORT_A, 8'h00, 16'd0);
                emit_wr(cdbs_pkg::REG_PORT_B, CTRL_CMD_MODE, 16'd0);
                emit_wr(cdbs_pkg::REG_PORT_B, CTRL_CMD_MODE, 16'd0);
                rs_mode_q = 1'b0;
                repeat (3) send_bus_byte(LCD_WAKE, 1'b0, init_pause_q);
                send_bus_byte(LCD_FUNC_SET, 1'b0, 16'd0);
                send_bus_byte(LCD_SHIFT, 1'b0, 16'd0);
                send_bus_byte(LCD_CLEAR, 1'b0, clear_pause_q);
                send_bus_byte(LCD_ENTRY, 1'b0, 16'd0);
                send_bus_byte(LCD_DISP_ON, 1'b0, 16'd0);
            end
            cdbs_pkg::OP_CLEAR: begin
                switch_mode(1'b0);
                send_bus_byte(LCD_CLEAR, 1'b0, clear_pause_q);
            end
            cdbs_pkg::OP_CURSOR: begin
                switch_mode(1'b0);
                // positions past the first line jump into the second
                pos = (pay > LINE1_LAST) ? pay + LINE2_OFFSET : pay;
                send_bus_byte(LCD_DDRAM | pos, 1'b0, 16'd0);
            end
            default: begin
                switch_mode(1'b1);
                send_bus_byte(pay, 1'b1, 16'd0);
            end
        endcase
        burst[burst_len-1].last = 1'b1;
    endfunction

    task automatic send_cmd(input cmd_row_t row);
        logic m;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.opcode  <= row.op;
        cmd_bus.payload <= row.pay;
        do @(posedge clk); while (!cmd_bus.ready);
        expand_cmd(row.op, row.pay);
        if (row.typed) begin
            // replace the expansion with the hand-written burst
            m = (row.op == cdbs_pkg::OP_WRITE);
            burst_len = 0;
            if (row.mode_wr) begin
                emit_wr(cdbs_pkg::REG_PORT_B, {7'b0, m}, 16'd0);
            end
            send_bus_byte(row.bus_byte, m, row.pause);
            burst[burst_len-1].last = 1'b1;
        end
        for (int k = 0; k < burst_len; k++) begin
            pending_writes.push_back(burst[k]);
        end
        n_cmds++;
        if (row.op == cdbs_pkg::OP_INIT) begin
            n_inits++;
        end
    endtask

    task automatic send_random();
        cmd_row_t row;
        row = '{cdbs_pkg::OP_WRITE, 8'h00, 1'b0, 1'b0, 8'h00, 16'd0};
        row.op  = ($urandom_range(0, 99) < 4) ? cdbs_pkg::OP_INIT
                                              : cdbs_pkg::t_opcode'($urandom_range(1, 3));
        row.pay = $urandom_range(0, 255);
        send_cmd(row);
    endtask

    // drop valid and hold until every expected write has come back
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input cdbs_pkg::t_cfg_idx idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == cdbs_pkg::CFG_INIT_PAUSE) begin
            init_pause_q = val;
        end else begin
            clear_pause_q = val;
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold on request
    initial begin
        wr_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                wr_bus.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                wr_bus.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                wr_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                wr_bus.ready <= 1'b1;
            end else begin
                wr_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        exp_wr_t want;
        if (rst_n && wr_bus.valid && wr_bus.ready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected write: dest_reg %02h reg_value %02h",
                       wr_bus.dest_reg, wr_bus.reg_value);
                errors++;
            end else begin
                want = pending_writes.pop_front();
                n_writes++;
                if (wr_bus.dest_reg !== want.addr) begin
                    $error("dest_reg: expected %02h, got %02h", want.addr, wr_bus.dest_reg);
                    errors++;
                end
                if (wr_bus.reg_value !== want.value) begin
                    $error("reg_value: expected %02h, got %02h", want.value,
                           wr_bus.reg_value);
                    errors++;
                end
                if (wr_bus.wait_us !== want.pause) begin
                    $error("wait_us: expected %0d, got %0d", want.pause, wr_bus.wait_us);
                    errors++;
                end
                if (wr_bus.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, wr_bus.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (wr_bus.valid && wr_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [15:0] init_val;
        logic [15:0] clear_val;
        rst_n           <= 1'b0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.opcode  <= cdbs_pkg::OP_INIT;
        cmd_bus.payload <= 8'h00;
        cfg_we          <= 1'b0;
        cfg_idx         <= cdbs_pkg::CFG_INIT_PAUSE;
        cfg_data        <= 16'h0000;
        rs_mode_q     = 1'b0;
        init_pause_q  = cdbs_pkg::INIT_PAUSE_RST;
        clear_pause_q = cdbs_pkg::CLEAR_PAUSE_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r]) begin
            send_cmd(directed_rows[r]);
        end
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin init_val = 16'h0000; clear_val = 16'h0000; end
                1: begin init_val = 16'hFFFF; clear_val = 16'hFFFF; end
                4: begin
                    init_val  = cdbs_pkg::INIT_PAUSE_RST;
                    clear_val = cdbs_pkg::CLEAR_PAUSE_RST;
                end
                default: begin
                    init_val  = $urandom_range(0, 65535);
                    clear_val = $urandom_range(0, 65535);
                end
            endcase
            cfg_write(cdbs_pkg::CFG_INIT_PAUSE, init_val);
            cfg_write(cdbs_pkg::CFG_CLEAR_PAUSE, clear_val);
            // run the last phase at full rate
            if (p == NUM_PHASES - 1) begin
                idle_on = 1'b0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // back-pressure the output long enough to fill the command queue
                if (p == 1 && i == 10) begin
                    rx_hold_req = 1'b1;
                end
                if (p == 2 && i == 20) begin
                    wait_drained();
                end
                send_random();
            end
            wait_drained();
        end

        $display("covered %0d commands (%0d init) and %0d expander writes", n_cmds, n_inits,
                 n_writes);
        $display("over %0d pause settings, including zero and all-ones", NUM_PHASES);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
